// ===== rtl/fwsm_pkg.sv =====
// Shared types and constants for the five-point weighted smoother.
package fwsm_pkg;

  localparam int FRAME_SIZE_DEF = 32;
  localparam int PIX_W          = 8;
  localparam int IDX_W          = 5;
  localparam int SUM_W          = PIX_W + 3;
  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W     = FIFO_PTR_W + 1;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } res_t;

  // Up to two results produced by one accepted request.
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } push_t;

endpackage

// ===== rtl/fwsm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fwsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/fwsm_stencil.sv =====
// Raster counters, line buffers and the five-point cross arithmetic.
module fwsm_stencil #(
  parameter int FRAME_SIZE = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic [fwsm_pkg::PIX_W-1:0] pixel_in,
  output fwsm_pkg::push_t          push
);
  import fwsm_pkg::*;

  localparam int AW = $clog2(FRAME_SIZE);
  localparam logic [AW-1:0] LAST = AW'(FRAME_SIZE - 1);

  logic [AW-1:0] row_count, row_count_next;
  logic [AW-1:0] col_count, col_count_next;
  logic [AW-1:0] east_addr;
  logic [PIX_W-1:0] centre, east, north, west;
  logic [SUM_W-1:0] sum;
  logic border;
  logic [PIX_W-1:0] val;

  always_comb begin
    row_count_next = row_count;
    col_count_next = col_count;
    if (accept) begin
      if (col_count == LAST) begin
        col_count_next = '0;
        row_count_next = (row_count == LAST) ? '0 : row_count + 1'b1;
      end else begin
        col_count_next = col_count + 1'b1;
      end
    end
  end

  // Prefetch for the next position; the wrapped east address only feeds borders.
  assign east_addr = (col_count_next == LAST) ? '0 : col_count_next + 1'b1;

  fwsm_ram #(.WIDTH(PIX_W), .DEPTH(FRAME_SIZE)) u_newer_c (
    .clk(clk), .wr_en(accept), .wr_addr(col_count), .wr_data(pixel_in),
    .rd_addr(col_count_next), .rd_data(centre)
  );

  fwsm_ram #(.WIDTH(PIX_W), .DEPTH(FRAME_SIZE)) u_newer_e (
    .clk(clk), .wr_en(accept), .wr_addr(col_count), .wr_data(pixel_in),
    .rd_addr(east_addr), .rd_data(east)
  );

  fwsm_ram #(.WIDTH(PIX_W), .DEPTH(FRAME_SIZE)) u_older (
    .clk(clk), .wr_en(accept), .wr_addr(col_count), .wr_data(centre),
    .rd_addr(col_count_next), .rd_data(north)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else begin
      row_count <= row_count_next;
      col_count <= col_count_next;
    end
  end

  // West neighbor is the previous centre of the same row.
  always_ff @(posedge clk) begin
    if (accept) begin
      west <= centre;
    end
  end

  assign border = (row_count == AW'(1)) || (col_count == '0) || (col_count == LAST);
  assign sum    = {1'b0, centre, 2'b00} + SUM_W'(north) + SUM_W'(pixel_in)
                + SUM_W'(west) + SUM_W'(east);
  assign val    = border ? centre : sum[SUM_W-1:3];

  always_comb begin
    push.v0       = accept && (row_count != '0);
    push.r0.pix   = val;
    push.r0.row   = IDX_W'(row_count - 1'b1);
    push.r0.col   = IDX_W'(col_count);
    push.r0.last  = 1'b0;
    push.v1       = accept && (row_count == LAST);
    push.r1.pix   = pixel_in;
    push.r1.row   = IDX_W'(row_count);
    push.r1.col   = IDX_W'(col_count);
    push.r1.last  = (col_count == LAST);
  end

endmodule

// ===== rtl/fwsm_out_fifo.sv =====
// Small result queue: takes up to two results per cycle, gives one while not stalled.
module fwsm_out_fifo (
  input  logic            clk,
  input  logic            rst,
  input  fwsm_pkg::push_t push,
  output logic            full2,
  output logic            out_valid,
  input  logic            out_stall,
  output fwsm_pkg::res_t  out_res
);
  import fwsm_pkg::*;

  res_t mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CNT_W-1:0] count, count_next;
  logic pop;
  logic [1:0] npush;
  res_t first, second;
  logic second_v;

  assign first    = push.v0 ? push.r0 : push.r1;
  assign second   = push.r1;
  assign second_v = push.v0 && push.v1;
  assign npush    = {1'b0, push.v0} + {1'b0, push.v1};

  assign out_valid = (count != '0);
  assign out_res   = mem[rd_ptr];
  assign pop       = out_valid && !out_stall;
  // Room for two is needed before a request is taken.
  assign full2     = (count > FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign count_next = count + FIFO_CNT_W'(npush) - FIFO_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(npush);
      rd_ptr <= rd_ptr + FIFO_PTR_W'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0 || push.v1) begin
      mem[wr_ptr] <= first;
    end
    if (second_v) begin
      mem[wr_ptr + 1'b1] <= second;
    end
  end

endmodule

// ===== rtl/five_point_weighted_smoother.sv =====
// Five-point weighted smoother: line-buffered cross stencil over a square raster frame.
// Accepted results are registered into the result queue and leave it in order.
// Throughput: 1 request per cycle while the queue has room; on the last row a request
// yields two results, so the single output port sets the pace there.
// Reset: raster counters and result queue clear; line buffers are not cleared,
// the first row of each frame fills them before they are read.
module five_point_weighted_smoother #(
  parameter int FRAME_SIZE = fwsm_pkg::FRAME_SIZE_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [fwsm_pkg::PIX_W-1:0] pixel_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [fwsm_pkg::PIX_W-1:0] pixel_out,
  output logic [fwsm_pkg::IDX_W-1:0] out_row,
  output logic [fwsm_pkg::IDX_W-1:0] out_col,
  output logic                       frame_last
);
  import fwsm_pkg::*;

  logic  accept;
  logic  full2;
  push_t push;
  res_t  out_res;

  // A request is taken only while the queue can hold both possible results,
  // and never while reset is held.
  assign in_stall = full2 || rst;
  assign accept   = in_valid && !in_stall;

  // Counters, three line-buffer RAMs (centre, east copy, older row) and the
  // (4*centre + N + S + W + E) >> 3 datapath; borders pass the centre.
  fwsm_stencil #(.FRAME_SIZE(FRAME_SIZE)) u_stencil (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .pixel_in (pixel_in),
    .push     (push)
  );

  // Queue decouples the input from output stalls.
  fwsm_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full2     (full2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign pixel_out  = out_res.pix;
  assign out_row    = out_res.row;
  assign out_col    = out_res.col;
  assign frame_last = out_res.last;

endmodule

// ===== dv/five_point_weighted_smoother_test.sv =====
// Self-checking testbench for the five-point weighted smoother.
`timescale 1ns / 1ps

module five_point_weighted_smoother_test;
  import fwsm_pkg::*;

  localparam int FRAME         = FRAME_SIZE_DEF;
  localparam int DIRECTED_PX   = 25;
  localparam int RANDOM_PX     = 1750;
  localparam int HOLD_CYCLES   = 80;     // long receiver hold-off, fills the result queue
  localparam int DRAIN_CYCLES  = 8;      // extra wait once no pixels are due
  localparam int CYCLE_LIMIT   = 200000; // watchdog limit; a legal run ends well before it
  localparam int MAX_PRINTED   = 40;

  // Receiver stall patterns; each runs for a random stretch of cycles.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  // Scoreboard: keeps its own copy of the line buffers and raster position,
  // predicts the output pixels for every accepted request and checks them in order.
  class smoother_scoreboard;
    logic [PIX_W-1:0] older_px [FRAME];
    logic [PIX_W-1:0] newer_px [FRAME];
    int unsigned      row_pos;
    int unsigned      col_pos;
    res_t             due_pixels [$];
    int unsigned      error_count;
    int unsigned      pixels_in;
    int unsigned      pixels_out;
    int unsigned      frame_ends;

    function new();
      row_pos     = 0;
      col_pos     = 0;
      error_count = 0;
      pixels_in   = 0;
      pixels_out  = 0;
      frame_ends  = 0;
    endfunction

    task report(string msg);
      if (error_count < MAX_PRINTED) begin
        $display("[%0t] smoother error: %s", $time, msg);
      end
      error_count++;
    endtask

    // Predict what this source pixel releases: the pixel one row up (from row 1 on),
    // plus the pixel itself when it lies on the last row.
    function void note_pixel_in(logic [PIX_W-1:0] pix);
      res_t        res;
      int unsigned prev_row;
      int unsigned stencil_sum;
      logic        on_border;
      pixels_in++;
      if (row_pos >= 1) begin
        prev_row  = row_pos - 1;
        on_border = (prev_row == 0) || (prev_row == FRAME - 1) ||
                    (col_pos == 0) || (col_pos == FRAME - 1);
        if (on_border) begin
          res.pix = newer_px[col_pos];
        end else begin
          // north sits in the older line; west was already rotated into it
          stencil_sum = 4 * int'(newer_px[col_pos]) + int'(older_px[col_pos]) +
                        int'(pix) + int'(older_px[col_pos - 1]) +
                        int'(newer_px[col_pos + 1]);
          res.pix = PIX_W'(stencil_sum >> 3);
        end
        res.row  = IDX_W'(prev_row);
        res.col  = IDX_W'(col_pos);
        res.last = 1'b0;
        due_pixels.push_back(res);
      end
      if (row_pos == FRAME - 1) begin
        res.pix  = pix;
        res.row  = IDX_W'(row_pos);
        res.col  = IDX_W'(col_pos);
        res.last = (col_pos == FRAME - 1);
        due_pixels.push_back(res);
      end
      older_px[col_pos] = newer_px[col_pos];
      newer_px[col_pos] = pix;
      if (col_pos == FRAME - 1) begin
        col_pos = 0;
        row_pos = (row_pos == FRAME - 1) ? 0 : row_pos + 1;
      end else begin
        col_pos = col_pos + 1;
      end
    endfunction

    task check_pixel_out(logic [PIX_W-1:0] pix, logic [IDX_W-1:0] row,
                         logic [IDX_W-1:0] col, logic last);
      res_t want;
      if (due_pixels.size() == 0) begin
        report($sformatf("unexpected pixel %0d at (%0d,%0d) last=%0b", pix, row, col, last));
      end else begin
        want = due_pixels.pop_front();
        pixels_out++;
        if (want.last) frame_ends++;
        if (pix !== want.pix)
          report($sformatf("pixel_out at (%0d,%0d): got %0d want %0d",
                           want.row, want.col, pix, want.pix));
        if (row !== want.row)
          report($sformatf("out_row: got %0d want %0d", row, want.row));
        if (col !== want.col)
          report($sformatf("out_col: got %0d want %0d", col, want.col));
        if (last !== want.last)
          report($sformatf("frame_last at (%0d,%0d): got %0b want %0b",
                           want.row, want.col, last, want.last));
      end
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic [PIX_W-1:0] pixel_in;
  logic             out_valid;
  logic             out_stall;
  logic [PIX_W-1:0] pixel_out;
  logic [IDX_W-1:0] out_row;
  logic [IDX_W-1:0] out_col;
  logic             frame_last;

  logic             hold_off;
  int unsigned      cycle_count = 0;
  stall_mode_e      stall_mode;
  int unsigned      stall_mode_left;
  smoother_scoreboard sb;

  five_point_weighted_smoother #(
    .FRAME_SIZE(FRAME)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pixel_in   (pixel_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_out  (pixel_out),
    .out_row    (out_row),
    .out_col    (out_col),
    .frame_last (frame_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still due", cycle_count,
               sb.due_pixels.size());
      $display("five_point_weighted_smoother: mismatch");
      $finish;
    end
  end

  // Offer one source pixel and hold it until the block takes the request.
  // Called at a rising edge; returns at the edge of acceptance.
  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    in_valid <= 1'b1;
    pixel_in <= pix;
    do @(posedge clk); while (in_stall);
    sb.note_pixel_in(pix);
  endtask

  // Sender gap; the idle payload carries junk that must be ignored.
  task automatic idle_sender(input int unsigned cycles);
    in_valid <= 1'b0;
    pixel_in <= PIX_W'($urandom_range(0, 255));
    repeat (cycles) @(posedge clk);
  endtask

  // Mostly uniform texture, with saturated runs so the stencil sum reaches
  // both 0 and its 2040 ceiling, and smooth drifts for near-equal neighbors.
  function automatic logic [PIX_W-1:0] pick_pixel(input logic [PIX_W-1:0] prev);
    int step;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: pick_pixel = PIX_W'($urandom_range(0, 255));
      6, 7:             pick_pixel = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: begin
        step = int'($urandom_range(0, 6)) - 3;
        if (int'(prev) + step < 0) pick_pixel = 8'h00;
        else if (int'(prev) + step > 255) pick_pixel = 8'hFF;
        else pick_pixel = PIX_W'(int'(prev) + step);
      end
    endcase
  endfunction

  // Receiver: sample at the edge, then pick the next stall value.
  // A hold-off request from the pressure process overrides every pattern.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_pixel_out(pixel_out, out_row, out_col, frame_last);
    end
    if (stall_mode_left == 0) begin
      stall_mode      = stall_mode_e'($urandom_range(0, 3));
      stall_mode_left = $urandom_range(20, 200);
    end else begin
      stall_mode_left = stall_mode_left - 1;
    end
    case (stall_mode)
      STALL_NONE:     out_stall <= hold_off;
      STALL_LIGHT:    out_stall <= hold_off | ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    out_stall <= hold_off | ($urandom_range(0, 3) != 0);
      STALL_PERIODIC: out_stall <= hold_off | ((cycle_count % 7) < 3);
      default:        out_stall <= hold_off;
    endcase
  end

  // Back-pressure: twice the receiver stops for a long stretch while the
  // sender keeps going, once mid-frame and once across the last row where
  // every request yields two pixels.
  initial begin
    hold_off = 1'b0;
    do @(posedge clk); while (sb.pixels_in < 400);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
    do @(posedge clk); while (sb.pixels_in < FRAME * (FRAME - 1) + 4);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Main sequence: reset, directed pixels, random bursts, drain, verdict.
  initial begin
    logic [PIX_W-1:0] directed_px [DIRECTED_PX];
    logic [PIX_W-1:0] prev_px;
    int unsigned      remaining;
    int unsigned      burst;

    sb              = new();
    rst             = 1'b1;
    in_valid        = 1'b0;
    pixel_in        = '0;
    out_stall       = 1'b0;
    stall_mode      = STALL_NONE;
    stall_mode_left = 0;

    // Walking ones and zeros plus both extremes; every input bit toggles.
    // These land on the first row, which only fills the line buffers.
    directed_px = '{8'h00, 8'hFF, 8'h01, 8'hFE, 8'h02, 8'hFD, 8'h04, 8'hFB,
                    8'h08, 8'hF7, 8'h10, 8'hEF, 8'h20, 8'hDF, 8'h40, 8'hBF,
                    8'h80, 8'h7F, 8'h55, 8'hAA, 8'hFF, 8'hFF, 8'h00, 8'h00,
                    8'hFF};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_px[i]) send_pixel(directed_px[i]);

    // Random part: a full frame (first row, interior, last row with its
    // double output, wrap at end of frame) and most of a second one.
    prev_px   = 8'h80;
    remaining = RANDOM_PX;
    while (remaining > 0) begin
      burst = $urandom_range(1, 48);
      if (burst > remaining) burst = remaining;
      repeat (burst) begin
        prev_px = pick_pixel(prev_px);
        send_pixel(prev_px);
      end
      remaining = remaining - burst;
      if (remaining > 0 && $urandom_range(0, 3) != 0) begin
        idle_sender($urandom_range(1, 6));
      end
    end
    in_valid <= 1'b0;

    while (sb.due_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.due_pixels.size() != 0) begin
      sb.report($sformatf("%0d predicted pixels never came out", sb.due_pixels.size()));
    end

    $display("covered %0d source pixels, %0d output pixels checked, %0d frame ends",
             sb.pixels_in, sb.pixels_out, sb.frame_ends);
    $display("receiver held off twice for %0d cycles with the sender still pushing",
             HOLD_CYCLES);
    if (sb.error_count == 0) begin
      $display("five_point_weighted_smoother: match");
    end else begin
      $display("%0d errors", sb.error_count);
      $display("five_point_weighted_smoother: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fwsm_pkg.sv
rtl/fwsm_ram.sv
rtl/fwsm_stencil.sv
rtl/fwsm_out_fifo.sv
rtl/five_point_weighted_smoother.sv
dv/five_point_weighted_smoother_test.sv
